>>> rtl/blst_pkg.sv
package blst_pkg;

   localparam int DEPTH_DEF  = 256;
   localparam int DATA_W_DEF = 32;

   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 8;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int COUNT_W  = 9;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND      = 3'd0,
      ACT_REMOVE_LAST = 3'd1,
      ACT_REMOVE_AT   = 3'd2,
      ACT_GET         = 3'd3,
      ACT_SET         = 3'd4,
      ACT_CONTAINS    = 3'd5,
      ACT_INDEX_OF    = 3'd6,
      ACT_CLEAR       = 3'd7
   } action_type;

endpackage

>>> rtl/blst_req_if.sv
interface blst_req_if;
   import blst_pkg::*;

   logic                 valid;
   logic                 ready;
   action_type           action;
   logic [INDEX_W-1:0]   index;
   logic [VALUE_W-1:0]   value;

   modport source (output valid, action, index, value, input ready);
   modport sink   (input valid, action, index, value, output ready);

endinterface

>>> rtl/blst_rsp_if.sv
interface blst_rsp_if;
   import blst_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   data;
   logic                 found;
   logic [POS_W-1:0]     position;
   logic [COUNT_W-1:0]   count;
   logic                 empty_res;
   logic                 error;

   modport source (output valid, data, found, position, count, empty_res, error, input ready);
   modport sink   (input valid, data, found, position, count, empty_res, error, output ready);

endinterface

>>> rtl/bounded_list_store.sv
// Channel   Dir  Payload                                        Handshake
// req_ch    in   action, index, value                           valid/ready
// rsp_ch    out  data, found, position, count, empty_res, error valid/ready
//
// Append, remove last, set and clear answer straight from idle; get reads one entry.
// Remove at moves the later entries down; contains / index of stop at the first hit.
// Both walk the word memory one entry per cycle through its single read port.
// Reset clears the element count, the state and the result valid flag; entries at or
// past the count are never used, so the memory needs no clearing pass and the block is ready right after reset.
// req_ch.ready is high only when idle and the result register is free or being drained.
module bounded_list_store #(
   parameter int DEPTH  = blst_pkg::DEPTH_DEF,
   parameter int DATA_W = blst_pkg::DATA_W_DEF
) (
   input  logic              clock,
   input  logic              reset,
   blst_req_if.sink          req_ch,
   blst_rsp_if.source        rsp_ch
);
   import blst_pkg::*;

   localparam int FW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = (FW > INDEX_W) ? FW : INDEX_W;

   typedef enum logic [1:0] {ST_IDLE, ST_GET, ST_SHIFT, ST_SEARCH} st_type;

   st_type              state_ff;
   logic [FW-1:0]       fill_ff;
   logic [FW-1:0]       ptr_ff;
   logic [FW-1:0]       cmp_ff;
   logic                have_ff;
   logic [DATA_W-1:0]   val_ff;
   logic [DATA_W-1:0]   rd_ff;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  data_ff;
   logic                found_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                err_ff;

   logic [DATA_W-1:0]   mem [DEPTH];

   logic                req_fire;
   logic [CW-1:0]       idx_c;
   logic [CW-1:0]       fill_c;
   logic                full;
   logic                set_ok;
   logic                last_cmp;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [DATA_W-1:0]   wr_data;

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign idx_c    = CW'(req_ch.index);
   assign fill_c   = CW'(fill_ff);
   assign full     = (fill_ff == FW'(DEPTH));
   assign set_ok   = (idx_c < fill_c) || ((idx_c == fill_c) && !full);
   assign last_cmp = (cmp_ff == fill_ff - 1'b1);

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.data      = data_ff;
   assign rsp_ch.found     = found_ff;
   assign rsp_ch.position  = pos_ff;
   assign rsp_ch.count     = COUNT_W'(fill_ff);
   assign rsp_ch.empty_res = (fill_ff == '0);
   assign rsp_ch.error     = err_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff[AW-1:0];
      wr_data = DATA_W'(req_ch.value);
      if (state_ff == ST_IDLE && req_fire) begin
         if (req_ch.action == ACT_APPEND) begin
            wr_en = !full;
         end else if (req_ch.action == ACT_SET) begin
            wr_en   = set_ok;
            wr_addr = idx_c[AW-1:0];
         end
      end else if (state_ff == ST_SHIFT && have_ff) begin
         // shift left: the word read from entry cmp moves down one place
         wr_en   = 1'b1;
         wr_addr = AW'(cmp_ff - 1'b1);
         wr_data = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[ptr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && !req_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  data_ff  <= '0;
                  found_ff <= 1'b0;
                  pos_ff   <= '0;
                  err_ff   <= 1'b0;
                  have_ff  <= 1'b0;
                  val_ff   <= DATA_W'(req_ch.value);
                  unique case (req_ch.action)
                     ACT_APPEND: begin
                        if (full) begin
                           err_ff <= 1'b1;
                        end else begin
                           fill_ff <= fill_ff + 1'b1;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     ACT_REMOVE_LAST: begin
                        if (fill_ff == '0) begin
                           err_ff <= 1'b1;
                        end else begin
                           fill_ff <= fill_ff - 1'b1;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     ACT_REMOVE_AT: begin
                        if (idx_c >= fill_c) begin
                           err_ff       <= 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else if (idx_c == fill_c - 1'b1) begin
                           fill_ff      <= fill_ff - 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           ptr_ff       <= FW'(idx_c) + 1'b1;
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= ST_SHIFT;
                        end
                     end
                     ACT_GET: begin
                        if (idx_c >= fill_c) begin
                           err_ff       <= 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           ptr_ff       <= FW'(idx_c);
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= ST_GET;
                        end
                     end
                     ACT_SET: begin
                        if (!set_ok) begin
                           err_ff <= 1'b1;
                        end else if (idx_c == fill_c) begin
                           fill_ff <= fill_ff + 1'b1;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     ACT_CONTAINS, ACT_INDEX_OF: begin
                        if (fill_ff == '0) begin
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           ptr_ff       <= '0;
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= ST_SEARCH;
                        end
                     end
                     ACT_CLEAR: begin
                        fill_ff      <= '0;
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_GET: begin
               have_ff <= 1'b1;
               if (have_ff) begin
                  data_ff      <= VALUE_W'(rd_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SHIFT: begin
               ptr_ff  <= ptr_ff + 1'b1;
               cmp_ff  <= ptr_ff;
               have_ff <= 1'b1;
               if (have_ff && last_cmp) begin
                  fill_ff      <= fill_ff - 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SEARCH: begin
               ptr_ff  <= ptr_ff + 1'b1;
               cmp_ff  <= ptr_ff;
               have_ff <= 1'b1;
               if (have_ff) begin
                  if (rd_ff == val_ff) begin
                     found_ff     <= 1'b1;
                     pos_ff       <= POS_W'(cmp_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else if (last_cmp) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
         endcase
      end
   end

endmodule

>>> rtl/blst_check.sv
module blst_check (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [blst_pkg::VALUE_W-1:0] rsp_data,
   input  logic                        rsp_found,
   input  logic [blst_pkg::POS_W-1:0]   rsp_position,
   input  logic [blst_pkg::COUNT_W-1:0] rsp_count,
   input  logic                        rsp_empty,
   input  logic                        rsp_error
);
   import blst_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_count)
         && $stable(rsp_error) && $stable(rsp_found) && $stable(rsp_position))
      else $error("result beat changed while stalled");

   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken while result slot busy");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_empty == (rsp_count == '0))
      else $error("empty flag disagrees with count");

   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> !rsp_error && rsp_data == '0 && !rsp_empty)
      else $error("search hit with error, data or empty list");

   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position != '0 |-> rsp_found)
      else $error("nonzero position without a hit");

endmodule

bind bounded_list_store blst_check u_blst_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_data     (rsp_ch.data),
   .rsp_found    (rsp_ch.found),
   .rsp_position (rsp_ch.position),
   .rsp_count    (rsp_ch.count),
   .rsp_empty    (rsp_ch.empty_res),
   .rsp_error    (rsp_ch.error)
);

>>> dv/blst_list_monitor.sv
module blst_list_monitor
   import blst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   blst_req_if                req_ch,
   blst_rsp_if                rsp_ch,
   output int                 fail_count,
   output int                 awaiting,
   output logic [COUNT_W-1:0] list_len
);

   typedef struct packed {
      logic [VALUE_W-1:0] data;
      logic               found;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
      logic               empty_res;
      logic               error;
   } list_result_t;

   logic [VALUE_W-1:0] words [DEPTH_DEF];
   logic [COUNT_W-1:0] length;
   list_result_t       results_due [$];
   int                 errors_seen;

   function automatic list_result_t apply_op(action_type act, logic [INDEX_W-1:0] idx,
                                             logic [VALUE_W-1:0] val);
      list_result_t r;
      int           i;
      r = '0;
      case (act)
         ACT_APPEND: begin
            if (length >= COUNT_W'(DEPTH_DEF)) begin
               r.error = 1'b1;
            end else begin
               words[length] = val;
               length = length + 1'b1;
            end
         end
         ACT_REMOVE_LAST: begin
            if (length == '0) begin
               r.error = 1'b1;
            end else begin
               length = length - 1'b1;
               words[length] = '0;
            end
         end
         ACT_REMOVE_AT: begin
            if (COUNT_W'(idx) >= length) begin
               r.error = 1'b1;
            end else begin
               for (i = int'(idx); i + 1 < int'(length); i++) words[i] = words[i + 1];
               length = length - 1'b1;
               words[length] = '0;
            end
         end
         ACT_GET: begin
            if (COUNT_W'(idx) >= length) r.error = 1'b1;
            else r.data = words[idx];
         end
         ACT_SET: begin
            if (COUNT_W'(idx) > length || int'(idx) >= DEPTH_DEF) begin
               r.error = 1'b1;
            end else begin
               if (COUNT_W'(idx) == length) length = length + 1'b1;
               words[idx] = val;
            end
         end
         ACT_CONTAINS, ACT_INDEX_OF: begin
            for (i = 0; i < int'(length) && !r.found; i++) begin
               if (words[i] == val) begin
                  r.found    = 1'b1;
                  r.position = POS_W'(i);
               end
            end
         end
         default: begin
            for (i = 0; i < DEPTH_DEF; i++) words[i] = '0;
            length = '0;
         end
      endcase
      r.count     = length;
      r.empty_res = (length == '0);
      return r;
   endfunction

   task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors_seen++;
      end
   endtask

   always @(posedge clock) begin
      list_result_t want;
      if (reset) begin
         for (int i = 0; i < DEPTH_DEF; i++) words[i] = '0;
         length = '0;
         results_due.delete();
      end else begin
         // result beat is checked before the request beat of the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: result beat with nothing awaited, got data %0h count %0h",
                        $time, rsp_ch.data, rsp_ch.count);
               errors_seen++;
            end else begin
               want = results_due.pop_front();
               check_field("data", want.data, rsp_ch.data);
               check_field("found", VALUE_W'(want.found), VALUE_W'(rsp_ch.found));
               check_field("position", VALUE_W'(want.position), VALUE_W'(rsp_ch.position));
               check_field("count", VALUE_W'(want.count), VALUE_W'(rsp_ch.count));
               check_field("empty_res", VALUE_W'(want.empty_res), VALUE_W'(rsp_ch.empty_res));
               check_field("error", VALUE_W'(want.error), VALUE_W'(rsp_ch.error));
            end
         end
         if (req_ch.valid && req_ch.ready)
            results_due.push_back(apply_op(req_ch.action, req_ch.index, req_ch.value));
      end
      fail_count <= errors_seen;
      awaiting   <= results_due.size();
      list_len   <= length;
   end

endmodule

>>> dv/bounded_list_store_test.sv
module bounded_list_store_test;
   import blst_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_take = 1'b0;

   int send_gap_pct = 0;
   int stall_pct    = 0;
   int fail_count;
   int awaiting;
   logic [COUNT_W-1:0] list_len;

   blst_req_if req_ch ();
   blst_rsp_if rsp_ch ();

   assign rsp_ch.ready = rsp_take;

   bounded_list_store dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   blst_list_monitor list_mon (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .awaiting   (awaiting),
      .list_len   (list_len)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_take <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic push_op(action_type act, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
      while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.index  <= idx;
      req_ch.value  <= val;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0, 1: return VALUE_W'($urandom_range(0, 7));
         2: return $urandom();
         default: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return 32'h8000_0000;
               default: return 32'h7fff_ffff;
            endcase
         end
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index(logic [COUNT_W-1:0] len);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            if (len == '0) return '0;
            return INDEX_W'($urandom_range(0, int'(len) - 1));
         end
         6: return INDEX_W'(len);
         7: return INDEX_W'(len + 1'b1);
         8: return INDEX_W'($urandom_range(0, 255));
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   initial begin
      action_type act;
      logic [INDEX_W-1:0] idx;
      int w;
      bit growing;

      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_APPEND;
      req_ch.index  <= '0;
      req_ch.value  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      push_op(ACT_REMOVE_LAST, 8'd0, 32'h0);
      push_op(ACT_REMOVE_AT, 8'd0, 32'h0);
      push_op(ACT_GET, 8'd0, 32'h0);
      push_op(ACT_SET, 8'd1, 32'h1111_1111);
      push_op(ACT_INDEX_OF, 8'd0, 32'h0);
      push_op(ACT_APPEND, 8'd0, 32'hffff_ffff);
      push_op(ACT_APPEND, 8'd0, 32'h0);
      push_op(ACT_SET, 8'd2, 32'h1234_5678);
      push_op(ACT_SET, 8'd0, 32'h8000_0000);
      push_op(ACT_GET, 8'd2, 32'h0);
      push_op(ACT_GET, 8'd3, 32'h0);
      push_op(ACT_CONTAINS, 8'd0, 32'h0);
      push_op(ACT_INDEX_OF, 8'd0, 32'h1234_5678);
      push_op(ACT_CONTAINS, 8'd0, 32'h5);
      push_op(ACT_REMOVE_AT, 8'd0, 32'h0);
      push_op(ACT_GET, 8'd0, 32'h0);
      push_op(ACT_REMOVE_AT, 8'hff, 32'h0);
      push_op(ACT_REMOVE_LAST, 8'd0, 32'h0);
      push_op(ACT_CLEAR, 8'd0, 32'h0);
      push_op(ACT_GET, 8'd0, 32'h0);
      push_op(ACT_APPEND, 8'hff, 32'ha5a5_a5a5);
      push_op(ACT_SET, 8'd0, 32'h5a5a_5a5a);
      push_op(ACT_REMOVE_AT, 8'd0, 32'h0);
      push_op(ACT_CLEAR, 8'hff, 32'hffff_ffff);

      // grow toward full, then drain, so full and long shifts get exercised
      growing = 1'b1;
      for (int n = 0; n < 950; n++) begin
         case ((n / 100) % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 78; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 78; end
            default: begin send_gap_pct = 24; stall_pct = 24; end
         endcase
         if (list_len == COUNT_W'(DEPTH_DEF) && $urandom_range(0, 3) == 0) growing = 1'b0;
         if (list_len <= 1) growing = 1'b1;
         w = $urandom_range(0, 99);
         if (growing) begin
            if (w < 55)      act = ACT_APPEND;
            else if (w < 65) act = ACT_SET;
            else if (w < 70) act = ACT_REMOVE_LAST;
            else if (w < 75) act = ACT_REMOVE_AT;
            else if (w < 85) act = ACT_GET;
            else if (w < 92) act = ACT_CONTAINS;
            else             act = ACT_INDEX_OF;
         end else begin
            if (w < 10)      act = ACT_APPEND;
            else if (w < 35) act = ACT_REMOVE_LAST;
            else if (w < 60) act = ACT_REMOVE_AT;
            else if (w < 70) act = ACT_GET;
            else if (w < 78) act = ACT_SET;
            else if (w < 86) act = ACT_CONTAINS;
            else if (w < 96) act = ACT_INDEX_OF;
            else             act = ACT_CLEAR;
         end
         idx = pick_index(list_len);
         push_op(act, idx, pick_value());
      end
      req_ch.valid <= 1'b0;

      send_gap_pct = 0;
      do @(posedge clock); while (awaiting != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && awaiting == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
rtl/blst_pkg.sv
rtl/blst_req_if.sv
rtl/blst_rsp_if.sv
rtl/bounded_list_store.sv
rtl/blst_check.sv
dv/blst_list_monitor.sv
dv/bounded_list_store_test.sv
